### hdl/bsm_pkg.sv
// shared types and constants for the bank switch mapper
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 16;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRG    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHR    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MIRROR = 2'd3;

  // word function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_PRG0      = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_PRG1      = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_PRG2      = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_CHR_LO    = 16'hB000;
  localparam logic [ADDR_W-1:0] ADDR_CHR_HI    = 16'hB007;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR    = 16'h9000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN    = 16'h9003;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_LOAD  = 16'h9004;
  localparam logic [ADDR_W-1:0] ADDR_RELOAD_HI = 16'h9005;
  localparam logic [ADDR_W-1:0] ADDR_RELOAD_LO = 16'h9006;

  localparam logic [SLOT_W-1:0] SLOT_PRG0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_PRG1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRG2 = 3'd2;

  localparam int BIT_MIRROR = 6;
  localparam int BIT_IRQ_EN = 7;

  localparam logic [DATA_W-1:0]  MIR_VERTICAL   = 8'd0;
  localparam logic [DATA_W-1:0]  MIR_HORIZONTAL = 8'd1;
  localparam logic [DATA_W-1:0]  CPL_RESET   = 8'd113;
  localparam logic [COUNT_W-1:0] COUNT_AFTER_IRQ = 16'hFFFF;

  // irq counter operations requested by one word
  typedef struct packed {
    logic              tick;
    logic              set_enable;
    logic              load_count;
    logic              set_hi;
    logic              set_lo;
    logic [DATA_W-1:0] data;
  } irq_op_t;

endpackage

### hdl/bsm_if.sv
// handshake channels for command words and event words
`timescale 1ns / 1ps

interface bsm_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [bsm_pkg::ADDR_W-1:0] addr;
  logic [bsm_pkg::DATA_W-1:0] wdata;

  modport source (output valid, func, addr, wdata, input ready);
  modport sink   (input valid, func, addr, wdata, output ready);
endinterface

interface bsm_evt_if;
  logic                       valid;
  logic                       ready;
  logic [bsm_pkg::KIND_W-1:0] event_kind;
  logic [bsm_pkg::SLOT_W-1:0] slot;
  logic [bsm_pkg::DATA_W-1:0] value;
  logic                       irq;

  modport source (output valid, event_kind, slot, value, irq, input ready);
  modport sink   (input valid, event_kind, slot, value, irq, output ready);
endinterface

### hdl/bsm_decode.sv
// address decode of one command word into an event and irq counter operations
`timescale 1ns / 1ps

module bsm_decode (
  input  logic                       func,
  input  logic [bsm_pkg::ADDR_W-1:0] addr,
  input  logic [bsm_pkg::DATA_W-1:0] wdata,
  output logic [bsm_pkg::KIND_W-1:0] event_kind,
  output logic [bsm_pkg::SLOT_W-1:0] slot,
  output logic [bsm_pkg::DATA_W-1:0] value,
  output bsm_pkg::irq_op_t           op
);

  always_comb begin
    event_kind    = bsm_pkg::KIND_NONE;
    slot          = '0;
    value         = '0;
    op            = '0;
    op.data       = wdata;
    if (func == bsm_pkg::FUNC_TICK) begin
      op.tick = 1'b1;
    end else begin
      case (addr) inside
        bsm_pkg::ADDR_PRG0: begin
          event_kind = bsm_pkg::KIND_PRG;
          slot       = bsm_pkg::SLOT_PRG0;
          value      = wdata;
        end
        bsm_pkg::ADDR_PRG1: begin
          event_kind = bsm_pkg::KIND_PRG;
          slot       = bsm_pkg::SLOT_PRG1;
          value      = wdata;
        end
        bsm_pkg::ADDR_PRG2: begin
          event_kind = bsm_pkg::KIND_PRG;
          slot       = bsm_pkg::SLOT_PRG2;
          value      = wdata;
        end
        [bsm_pkg::ADDR_CHR_LO:bsm_pkg::ADDR_CHR_HI]: begin
          event_kind = bsm_pkg::KIND_CHR;
          slot       = addr[bsm_pkg::SLOT_W-1:0];
          value      = wdata;
        end
        bsm_pkg::ADDR_MIRROR: begin
          event_kind = bsm_pkg::KIND_MIRROR;
          value      = wdata[bsm_pkg::BIT_MIRROR] ? bsm_pkg::MIR_VERTICAL
                                                  : bsm_pkg::MIR_HORIZONTAL;
        end
        bsm_pkg::ADDR_IRQ_EN:    op.set_enable = 1'b1;
        bsm_pkg::ADDR_IRQ_LOAD:  op.load_count = 1'b1;
        bsm_pkg::ADDR_RELOAD_HI: op.set_hi     = 1'b1;
        bsm_pkg::ADDR_RELOAD_LO: op.set_lo     = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### hdl/bsm_irq.sv
// scanline irq counter with reload latch and cycles-per-line register
`timescale 1ns / 1ps

module bsm_irq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bsm_pkg::DATA_W-1:0] cfg_wdata,
  input  logic                       step,
  input  bsm_pkg::irq_op_t           op,
  output logic                       raise
);

  logic [bsm_pkg::DATA_W-1:0]  cycles_per_line;
  logic                        irq_enable;
  logic                        irq_enable_next;
  logic [bsm_pkg::COUNT_W-1:0] irq_reload;
  logic [bsm_pkg::COUNT_W-1:0] irq_reload_next;
  logic [bsm_pkg::COUNT_W-1:0] irq_count;
  logic [bsm_pkg::COUNT_W-1:0] irq_count_next;
  logic [bsm_pkg::COUNT_W-1:0] cpl_wide;
  logic                        expired;

  assign cpl_wide = {{(bsm_pkg::COUNT_W-bsm_pkg::DATA_W){1'b0}}, cycles_per_line};
  assign expired  = irq_count <= cpl_wide;
  assign raise    = op.tick && irq_enable && expired;

  always_comb begin
    irq_enable_next = irq_enable;
    irq_reload_next = irq_reload;
    irq_count_next  = irq_count;
    if (op.tick) begin
      if (irq_enable) begin
        if (expired) begin
          irq_enable_next = 1'b0;
          irq_count_next  = bsm_pkg::COUNT_AFTER_IRQ;
        end else begin
          irq_count_next = irq_count - cpl_wide;
        end
      end
    end else if (op.set_enable) begin
      irq_enable_next = op.data[bsm_pkg::BIT_IRQ_EN];
    end else if (op.load_count) begin
      irq_count_next = irq_reload;
    end else if (op.set_hi) begin
      irq_reload_next = {op.data, irq_reload[bsm_pkg::DATA_W-1:0]};
    end else if (op.set_lo) begin
      irq_reload_next = {irq_reload[bsm_pkg::COUNT_W-1:bsm_pkg::DATA_W], op.data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_line <= bsm_pkg::CPL_RESET;
      irq_enable      <= 1'b0;
      irq_reload      <= '0;
      irq_count       <= '0;
    end else begin
      if (cfg_we) begin
        cycles_per_line <= cfg_wdata;
      end
      if (step) begin
        irq_enable <= irq_enable_next;
        irq_reload <= irq_reload_next;
        irq_count  <= irq_count_next;
      end
    end
  end

endmodule

### hdl/bank_switch_mapper_with_scanline_irq_core.sv
// top level of the bank switch mapper with scanline irq counter
`timescale 1ns / 1ps

// Takes one command word per cycle on cmd while evt is not stalled (a cpu
// register write or a scanline tick) and returns exactly one event word per
// command on evt, in order. Sustained rate is one word per clock while evt
// accepts; each word passes the input register and then the event register,
// with the decode and the 16-bit counter subtract/compare between them. A
// command is taken whenever the input register is empty or its word moves
// on to the event register in the same cycle, so one word can wait in each
// register while evt is stalled. cycles_per_line is written through
// cfg_we/cfg_wdata and should only change while no words are in flight.
module bank_switch_mapper_with_scanline_irq_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bsm_pkg::DATA_W-1:0] cfg_wdata,
  bsm_cmd_if.sink                    cmd,
  bsm_evt_if.source                  evt
);

  // input register stage
  logic                       in_valid;
  logic                       in_func;
  logic [bsm_pkg::ADDR_W-1:0] in_addr;
  logic [bsm_pkg::DATA_W-1:0] in_wdata;

  // event register stage
  logic                       out_valid;
  logic [bsm_pkg::KIND_W-1:0] out_kind;
  logic [bsm_pkg::SLOT_W-1:0] out_slot;
  logic [bsm_pkg::DATA_W-1:0] out_value;
  logic                       out_irq;

  logic                       out_free;
  logic                       advance;
  logic                       cmd_take;

  logic [bsm_pkg::KIND_W-1:0] dec_kind;
  logic [bsm_pkg::SLOT_W-1:0] dec_slot;
  logic [bsm_pkg::DATA_W-1:0] dec_value;
  bsm_pkg::irq_op_t           dec_op;
  logic                       raise;

  // event register frees up when empty or drained this cycle
  assign out_free  = !out_valid || evt.ready;
  assign advance   = in_valid && out_free;
  assign cmd.ready = !in_valid || advance;
  assign cmd_take  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      in_func  <= cmd.func;
      in_addr  <= cmd.addr;
      in_wdata <= cmd.wdata;
    end
  end

  bsm_decode u_decode (
    .func       (in_func),
    .addr       (in_addr),
    .wdata      (in_wdata),
    .event_kind (dec_kind),
    .slot       (dec_slot),
    .value      (dec_value),
    .op         (dec_op)
  );

  // counter state commits only when the word moves to the event register
  bsm_irq u_irq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .op        (dec_op),
    .raise     (raise)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind  <= dec_kind;
      out_slot  <= dec_slot;
      out_value <= dec_value;
      out_irq   <= raise;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.slot       = out_slot;
  assign evt.value      = out_value;
  assign evt.irq        = out_irq;

endmodule
